// ----- hdl/ccfb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ccfb_pkg: camera command frame builder package
// Types, microcode ROM and character table shared by the frame builder.
// ----------------------------------------------------------------------------
package ccfb_pkg;

  localparam int unsigned OpcodeW = 3;
  localparam int unsigned TextW   = 40;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned PosW    = 16;
  localparam int unsigned NumPos  = 4;
  localparam int unsigned LevelW  = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned NumChar = 10;
  localparam int unsigned HalfChr = 5;
  localparam int unsigned CharIdxW = 4;
  localparam int unsigned PcW     = 7;

  localparam logic [LevelW-1:0] LevelMax = 2'd3;
  localparam logic [LevelW-1:0] LevelMin = 2'd0;

  localparam logic [PosW-1:0] PosReset0 = 16'h0000;
  localparam logic [PosW-1:0] PosReset1 = 16'h2000;
  localparam logic [PosW-1:0] PosReset2 = 16'h4000;
  localparam logic [PosW-1:0] PosReset3 = 16'h7AC0;

  typedef enum logic [OpcodeW-1:0] {
    OP_ZOOM_IN   = 3'd0,
    OP_ZOOM_OUT  = 3'd1,
    OP_TTL_SETUP = 3'd2,
    OP_TTL_CLEAR = 3'd3,
    OP_TTL_ON    = 3'd4,
    OP_TTL_OFF   = 3'd5,
    OP_TTL_LINE1 = 3'd6,
    OP_TTL_LINE2 = 3'd7
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ZOOM_POS0 = 2'd0,
    REG_ZOOM_POS1 = 2'd1,
    REG_ZOOM_POS2 = 2'd2,
    REG_ZOOM_POS3 = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SRC_CONST = 2'd0,
    SRC_NIB   = 2'd1,
    SRC_CHAR  = 2'd2
  } src_e;

  typedef enum logic [2:0] {
    NX_STEP = 3'd0,
    NX_JUMP = 3'd1,
    NX_ZIN  = 3'd2,
    NX_ZOUT = 3'd3,
    NX_END  = 3'd4
  } nxt_e;

  typedef struct packed {
    logic              emit;
    src_e              src;
    logic [ByteW-1:0]  arg;
    nxt_e              nxt;
    logic [PcW-1:0]    tgt;
  } ucode_t;

  typedef struct packed {
    logic              load;
    logic              emit;
    logic              last;
    logic              inc;
    logic              dec;
    src_e              src;
    logic [ByteW-1:0]  arg;
  } ccfb_ctrl_t;

  typedef struct packed {
    logic at_max;
    logic at_min;
    logic out_free;
  } ccfb_stat_t;

  // program entry points
  localparam logic [PcW-1:0] PgZin   = 7'd0;
  localparam logic [PcW-1:0] PgZout  = 7'd1;
  localparam logic [PcW-1:0] PgZoom  = 7'd2;
  localparam logic [PcW-1:0] PgSetup = 7'd11;
  localparam logic [PcW-1:0] PgClear = 7'd27;
  localparam logic [PcW-1:0] PgOn    = 7'd33;
  localparam logic [PcW-1:0] PgOff   = 7'd39;
  localparam logic [PcW-1:0] PgLine1 = 7'd45;
  localparam logic [PcW-1:0] PgLine2 = 7'd50;
  localparam logic [PcW-1:0] PgChars = 7'd55;

  localparam logic [ByteW-1:0] BtAddr  = 8'h81;
  localparam logic [ByteW-1:0] BtCmd   = 8'h01;
  localparam logic [ByteW-1:0] BtCat   = 8'h04;
  localparam logic [ByteW-1:0] BtZoom  = 8'h47;
  localparam logic [ByteW-1:0] BtTitle = 8'h73;
  localparam logic [ByteW-1:0] BtDisp  = 8'h74;
  localparam logic [ByteW-1:0] BtTerm  = 8'hFF;
  localparam logic [ByteW-1:0] BtUnk   = 8'h1B;

  function automatic ucode_t mk(logic e, src_e s, logic [ByteW-1:0] a, nxt_e n,
                                logic [PcW-1:0] t);
    ucode_t w;
    w.emit = e;
    w.src  = s;
    w.arg  = a;
    w.nxt  = n;
    w.tgt  = t;
    return w;
  endfunction

  function automatic ucode_t k(logic [ByteW-1:0] a);
    return mk(1'b1, SRC_CONST, a, NX_STEP, '0);
  endfunction

  function automatic ucode_t kend();
    return mk(1'b1, SRC_CONST, BtTerm, NX_END, '0);
  endfunction

  function automatic logic [PcW-1:0] entry(opcode_e op);
    logic [PcW-1:0] pc;
    unique case (op)
      OP_ZOOM_IN:   pc = PgZin;
      OP_ZOOM_OUT:  pc = PgZout;
      OP_TTL_SETUP: pc = PgSetup;
      OP_TTL_CLEAR: pc = PgClear;
      OP_TTL_ON:    pc = PgOn;
      OP_TTL_OFF:   pc = PgOff;
      OP_TTL_LINE1: pc = PgLine1;
      OP_TTL_LINE2: pc = PgLine2;
      default:      pc = PgClear;
    endcase
    return pc;
  endfunction

  function automatic ucode_t ucode(logic [PcW-1:0] a);
    ucode_t w;
    unique case (a)
      PgZin:        w = mk(1'b0, SRC_CONST, '0, NX_ZIN, PgZoom);
      PgZout:       w = mk(1'b0, SRC_CONST, '0, NX_ZOUT, PgZoom);
      // zoom frame
      PgZoom:       w = k(BtAddr);
      PgZoom+7'd1:  w = k(BtCmd);
      PgZoom+7'd2:  w = k(BtCat);
      PgZoom+7'd3:  w = k(BtZoom);
      PgZoom+7'd4:  w = mk(1'b1, SRC_NIB, 8'd3, NX_STEP, '0);
      PgZoom+7'd5:  w = mk(1'b1, SRC_NIB, 8'd2, NX_STEP, '0);
      PgZoom+7'd6:  w = mk(1'b1, SRC_NIB, 8'd1, NX_STEP, '0);
      PgZoom+7'd7:  w = mk(1'b1, SRC_NIB, 8'd0, NX_STEP, '0);
      PgZoom+7'd8:  w = kend();
      // title setup
      PgSetup:      w = k(BtAddr);
      PgSetup+7'd1: w = k(BtCmd);
      PgSetup+7'd2: w = k(BtCat);
      PgSetup+7'd3: w = k(BtTitle);
      PgSetup+7'd7: w = k(8'h03);
      PgSetup+7'd4, PgSetup+7'd5, PgSetup+7'd6, PgSetup+7'd8, PgSetup+7'd9,
      PgSetup+7'd10, PgSetup+7'd11, PgSetup+7'd12, PgSetup+7'd13,
      PgSetup+7'd14: w = k(8'h00);
      PgSetup+7'd15: w = kend();
      // title clear / on / off
      PgClear, PgOn, PgOff:                   w = k(BtAddr);
      PgClear+7'd1, PgOn+7'd1, PgOff+7'd1:    w = k(BtCmd);
      PgClear+7'd2, PgOn+7'd2, PgOff+7'd2:    w = k(BtCat);
      PgClear+7'd3, PgOn+7'd3, PgOff+7'd3:    w = k(BtDisp);
      PgClear+7'd4: w = k(8'h00);
      PgOn+7'd4:    w = k(8'h02);
      PgOff+7'd4:   w = k(8'h03);
      PgClear+7'd5, PgOn+7'd5, PgOff+7'd5:    w = kend();
      // title lines
      PgLine1, PgLine2:                       w = k(BtAddr);
      PgLine1+7'd1, PgLine2+7'd1:             w = k(BtCmd);
      PgLine1+7'd2, PgLine2+7'd2:             w = k(BtCat);
      PgLine1+7'd3, PgLine2+7'd3:             w = k(BtTitle);
      PgLine1+7'd4: w = mk(1'b1, SRC_CONST, 8'h01, NX_JUMP, PgChars);
      PgLine2+7'd4: w = mk(1'b1, SRC_CONST, 8'h02, NX_JUMP, PgChars);
      PgChars:       w = mk(1'b1, SRC_CHAR, 8'd0, NX_STEP, '0);
      PgChars+7'd1:  w = mk(1'b1, SRC_CHAR, 8'd1, NX_STEP, '0);
      PgChars+7'd2:  w = mk(1'b1, SRC_CHAR, 8'd2, NX_STEP, '0);
      PgChars+7'd3:  w = mk(1'b1, SRC_CHAR, 8'd3, NX_STEP, '0);
      PgChars+7'd4:  w = mk(1'b1, SRC_CHAR, 8'd4, NX_STEP, '0);
      PgChars+7'd5:  w = mk(1'b1, SRC_CHAR, 8'd5, NX_STEP, '0);
      PgChars+7'd6:  w = mk(1'b1, SRC_CHAR, 8'd6, NX_STEP, '0);
      PgChars+7'd7:  w = mk(1'b1, SRC_CHAR, 8'd7, NX_STEP, '0);
      PgChars+7'd8:  w = mk(1'b1, SRC_CHAR, 8'd8, NX_STEP, '0);
      PgChars+7'd9:  w = mk(1'b1, SRC_CHAR, 8'd9, NX_STEP, '0);
      PgChars+7'd10: w = kend();
      default:       w = mk(1'b0, SRC_CONST, '0, NX_END, '0);
    endcase
    return w;
  endfunction

  // camera character table
  function automatic logic [ByteW-1:0] map_char(logic [ByteW-1:0] c);
    logic [ByteW-1:0] m;
    if (c >= 8'h41 && c <= 8'h5A) begin
      m = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      m = c - 8'h61;
    end else if (c >= 8'h31 && c <= 8'h39) begin
      m = c - 8'h13;
    end else begin
      case (c)
        8'h26:   m = 8'h1A;
        8'h3F:   m = 8'h1C;
        8'h21:   m = 8'h1D;
        8'h30:   m = 8'h27;
        8'h22:   m = 8'h49;
        8'h3A:   m = 8'h4A;
        8'h27:   m = 8'h4B;
        8'h2E:   m = 8'h4C;
        8'h2C:   m = 8'h4D;
        8'h5C:   m = 8'h4E;
        8'h2D:   m = 8'h4F;
        default: m = BtUnk;
      endcase
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/ccfb_intf.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ccfb_intf: frame builder channels
// Command, frame byte and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ccfb_cmd_if;
  import ccfb_pkg::*;
  logic                valid;
  logic                ready;
  logic [OpcodeW-1:0]  opcode;
  logic [TextW-1:0]    text_first_half;
  logic [TextW-1:0]    text_second_half;
  modport source (output valid, opcode, text_first_half, text_second_half, input ready);
  modport sink   (input valid, opcode, text_first_half, text_second_half, output ready);
endinterface

interface ccfb_byte_if;
  import ccfb_pkg::*;
  logic              valid;
  logic              ready;
  logic [ByteW-1:0]  frame_byte;
  logic              last_byte;
  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

interface ccfb_cfg_if;
  import ccfb_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [PosW-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/ccfb_seq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ccfb_seq: microcode sequencer
// Step counter over the microcode ROM with conditional zoom-limit jumps.
// ----------------------------------------------------------------------------
module ccfb_seq (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cmd_valid_i,
  output      logic                  cmd_ready_o,
  input  wire logic [ccfb_pkg::OpcodeW-1:0] opcode_i,
  input  wire ccfb_pkg::ccfb_stat_t  stat_i,
  output      ccfb_pkg::ccfb_ctrl_t  ctrl_o
);
  import ccfb_pkg::*;

  logic           busy_q, busy_d;
  logic [PcW-1:0] pc_q, pc_d;
  ucode_t         w;
  logic           go, load;

  assign w           = ucode(pc_q);
  assign cmd_ready_o = !busy_q;
  assign load        = cmd_valid_i && !busy_q;
  assign go          = busy_q && (!w.emit || stat_i.out_free);

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    ctrl_o = '0;
    ctrl_o.load = load;
    ctrl_o.src  = w.src;
    ctrl_o.arg  = w.arg;
    ctrl_o.emit = go && w.emit;
    ctrl_o.last = w.nxt == NX_END;
    if (load) begin
      busy_d = 1'b1;
      pc_d   = entry(opcode_e'(opcode_i));
    end else if (go) begin
      unique case (w.nxt)
        NX_STEP: pc_d = pc_q + 7'd1;
        NX_JUMP: pc_d = w.tgt;
        NX_ZIN: begin
          if (stat_i.at_max) begin
            busy_d = 1'b0;
          end else begin
            ctrl_o.inc = 1'b1;
            pc_d       = w.tgt;
          end
        end
        NX_ZOUT: begin
          if (stat_i.at_min) begin
            busy_d = 1'b0;
          end else begin
            ctrl_o.dec = 1'b1;
            pc_d       = w.tgt;
          end
        end
        default: busy_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/ccfb_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ccfb_dp: frame builder datapath
// Zoom level, position registers, title text, byte select and output word.
// ----------------------------------------------------------------------------
module ccfb_dp (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ccfb_pkg::ccfb_ctrl_t  ctrl_i,
  output      ccfb_pkg::ccfb_stat_t  stat_o,
  input  wire logic [ccfb_pkg::TextW-1:0] text_first_half_i,
  input  wire logic [ccfb_pkg::TextW-1:0] text_second_half_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [ccfb_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [ccfb_pkg::PosW-1:0]    cfg_data_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      logic [ccfb_pkg::ByteW-1:0] out_byte_o,
  output      logic                  out_last_o
);
  import ccfb_pkg::*;

  logic [PosW-1:0]   pos_q [NumPos];
  logic [LevelW-1:0] level_q;
  logic [ByteW-1:0]  chars_q [NumChar];
  logic              valid_q;
  logic [ByteW-1:0]  byte_q, byte_d;
  logic              last_q;
  logic [PosW-1:0]   pos;

  assign pos             = pos_q[level_q];
  assign stat_o.at_max   = level_q == LevelMax;
  assign stat_o.at_min   = level_q == LevelMin;
  assign stat_o.out_free = !valid_q || out_ready_i;
  assign out_valid_o     = valid_q;
  assign out_byte_o      = byte_q;
  assign out_last_o      = last_q;

  always_comb begin
    case (ctrl_i.src)
      SRC_NIB:  byte_d = {4'h0, pos[ctrl_i.arg[1:0]*4 +: 4]};
      SRC_CHAR: byte_d = map_char(chars_q[ctrl_i.arg[CharIdxW-1:0]]);
      default:  byte_d = ctrl_i.arg;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q[REG_ZOOM_POS0] <= PosReset0;
      pos_q[REG_ZOOM_POS1] <= PosReset1;
      pos_q[REG_ZOOM_POS2] <= PosReset2;
      pos_q[REG_ZOOM_POS3] <= PosReset3;
      level_q <= LevelMin;
      valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pos_q[cfg_index_i] <= cfg_data_i;
      end
      if (ctrl_i.inc) begin
        level_q <= level_q + 2'd1;
      end else if (ctrl_i.dec) begin
        level_q <= level_q - 2'd1;
      end
      if (ctrl_i.emit) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      for (int i = 0; i < HalfChr; i++) begin
        chars_q[i]           <= text_first_half_i[i*8 +: 8];
        chars_q[i + HalfChr] <= text_second_half_i[i*8 +: 8];
      end
    end
    if (ctrl_i.emit) begin
      byte_q <= byte_d;
      last_q <= ctrl_i.last;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/camera_command_frame_builder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// camera_command_frame_builder: camera command to serial frame
// Runs one microcode program per command and sends the frame word by word.
// ----------------------------------------------------------------------------
//  channel   dir  words
//  cmd_i     in   opcode, text_first_half, text_second_half
//  frame_o   out  frame_byte, last_byte
//  cfg_i     in   index, data (zoom positions 0..3)
//
//  One microcode step per cycle, one frame word per emitting step.
//  A zoom beyond a limit ends the command without a frame.
//  A stalled output holds the step counter on emitting steps.
//  Reset clears the zoom level and loads the default positions.
// ----------------------------------------------------------------------------
module camera_command_frame_builder (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  ccfb_cmd_if.sink     cmd_i,
  ccfb_byte_if.source  frame_o,
  ccfb_cfg_if.sink     cfg_i
);
  import ccfb_pkg::*;

  ccfb_ctrl_t ctrl;
  ccfb_stat_t stat;

  assign cfg_i.ready = 1'b1;

  ccfb_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_i.ready),
    .opcode_i    (cmd_i.opcode),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  ccfb_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ctrl_i             (ctrl),
    .stat_o             (stat),
    .text_first_half_i  (cmd_i.text_first_half),
    .text_second_half_i (cmd_i.text_second_half),
    .cfg_we_i           (cfg_i.valid),
    .cfg_index_i        (cfg_i.index),
    .cfg_data_i         (cfg_i.data),
    .out_valid_o        (frame_o.valid),
    .out_ready_i        (frame_o.ready),
    .out_byte_o         (frame_o.frame_byte),
    .out_last_o         (frame_o.last_byte)
  );

endmodule
`default_nettype wire
